[rtl/olid_pkg.sv]
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and codes for the ordered list block: request functions,
// response status codes, controller-to-datapath command and status word.
// ----------------------------------------------------------------------------
package olid_pkg;

   localparam int DATA_W       = 32;
   localparam int FUNC_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int CAPACITY_DEF = 16;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PREPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_LIST    = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] RSP_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_DELETED   = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] RSP_LISTED    = 3'd5;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_APPEND,
      CMD_PREPEND,
      CMD_DELETE,
      CMD_LIST_FIRST,
      CMD_LIST_NEXT
   } cmd_type;

   // datapath flags seen by the controller
   typedef struct packed {
      logic empty;      // no entries stored
      logic list_one;   // exactly one entry stored
      logic list_last;  // listing walk is on its final entry
   } dp_status_type;

endpackage

[rtl/olid_datapath.sv]
// ----------------------------------------------------------------------------
// olid_datapath
// Row of value cells with parallel compare and shift, fill count, listing
// walk counter and the response word register.
// ----------------------------------------------------------------------------
module olid_datapath #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  olid_pkg::cmd_type                    cmd,
   input  logic signed [olid_pkg::DATA_W-1:0]   req_value,
   output olid_pkg::dp_status_type              dp_status,
   output logic [olid_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [olid_pkg::DATA_W-1:0]   rsp_entry_value,
   output logic                                 rsp_last_result
);
   import olid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [DATA_W-1:0] cell_ff [CAPACITY];
   logic signed [DATA_W-1:0] cell_in [CAPACITY];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     last_ff, last_in;
   logic                     load_out;

   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] pre_match;   // a match at or below this cell
   logic                found, full, empty;

   // per-cell compare against the operand, only inside the filled range
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
      assign match[g]     = (CNT_W'(g) < count_ff) && (cell_ff[g] == req_value);
      assign pre_match[g] = |match[g:0];
   end

   assign found = |match;
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   assign dp_status.empty     = empty;
   assign dp_status.list_one  = (count_ff == CNT_W'(1));
   assign dp_status.list_last = (left_ff == CNT_W'(1));

   always_comb begin
      cell_in   = cell_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      load_out  = 1'b0;
      status_in = status_ff;
      value_in  = req_value;
      last_in   = 1'b1;
      unique case (cmd) inside
         CMD_NONE: begin
         end
         CMD_APPEND: begin
            load_out = 1'b1;
            if (full) begin
               status_in = RSP_FULL;
            end else begin
               status_in = RSP_INSERTED;
               count_in  = count_ff + CNT_W'(1);
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_W'(i) == count_ff) cell_in[i] = req_value;
               end
            end
         end
         CMD_PREPEND: begin
            load_out = 1'b1;
            if (full) begin
               status_in = RSP_FULL;
            end else begin
               status_in = RSP_INSERTED;
               count_in  = count_ff + CNT_W'(1);
               for (int i = 1; i < CAPACITY; i++) begin
                  cell_in[i] = cell_ff[i-1];
               end
               cell_in[0] = req_value;
            end
         end
         CMD_DELETE: begin
            load_out = 1'b1;
            if (empty) begin
               status_in = RSP_EMPTY;
            end else if (found) begin
               status_in = RSP_DELETED;
               count_in  = count_ff - CNT_W'(1);
               // cells from the first match upward close the gap
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (pre_match[i]) cell_in[i] = cell_ff[i+1];
               end
            end else begin
               status_in = RSP_NOT_FOUND;
            end
         end
         CMD_LIST_FIRST, CMD_LIST_NEXT: begin
            load_out = 1'b1;
            if (cmd == CMD_LIST_FIRST && empty) begin
               status_in = RSP_EMPTY;
            end else begin
               status_in = RSP_LISTED;
               value_in  = cell_ff[0];
               if (cmd == CMD_LIST_FIRST) begin
                  last_in = (count_ff == CNT_W'(1));
                  left_in = count_ff - CNT_W'(1);
               end else begin
                  last_in = (left_ff == CNT_W'(1));
                  left_in = left_ff - CNT_W'(1);
               end
               // rotate the filled range by one; a full walk restores it
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (CNT_W'(i + 1) < count_ff) cell_in[i] = cell_ff[i+1];
               end
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_W'(i + 1) == count_ff) cell_in[i] = cell_ff[0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (load_out) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         left_ff  <= '0;
      end else begin
         count_ff <= count_in;
         left_ff  <= left_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_value = value_ff;
   assign rsp_last_result = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_APPEND || cmd == CMD_PREPEND) && !full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_DELETE && found |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not shrink the list");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_LIST_NEXT |-> left_ff != '0 && left_ff < count_ff)
      else $error("listing walk past the tail");

endmodule

[rtl/olid_controller.sv]
// ----------------------------------------------------------------------------
// olid_controller
// Request decode, listing walk sequencing and response word valid flag.
// ----------------------------------------------------------------------------
module olid_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [olid_pkg::FUNC_W-1:0]      req_func,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  olid_pkg::dp_status_type          dp_status,
   output olid_pkg::cmd_type                cmd
);
   import olid_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LIST = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // output word register may be refilled when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NONE;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               rsp_valid_in = 1'b1;
               unique case (req_func)
                  FUNC_APPEND:  cmd = CMD_APPEND;
                  FUNC_PREPEND: cmd = CMD_PREPEND;
                  FUNC_DELETE:  cmd = CMD_DELETE;
                  FUNC_LIST: begin
                     cmd = CMD_LIST_FIRST;
                     if (!dp_status.empty && !dp_status.list_one) state_in = S_LIST;
                  end
                  default: cmd = CMD_NONE;
               endcase
            end
         end
         S_LIST: begin
            if (out_free) begin
               cmd          = CMD_LIST_NEXT;
               rsp_valid_in = 1'b1;
               if (dp_status.list_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_walk_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST |-> req_stall)
      else $error("request taken during listing walk");

   a_cmd_fills_out: assert property (@(posedge clock) disable iff (reset)
      cmd != CMD_NONE |=> rsp_valid_ff)
      else $error("command issued without a response word");

   a_walk_enters_on_list: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && state_in == S_LIST |-> cmd == CMD_LIST_FIRST)
      else $error("listing walk started without a list request");

endmodule

[rtl/ordered_list_insert_delete_top.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top
// Fixed-capacity ordered list of signed 32-bit values: append, prepend,
// delete first match, list all from head to tail.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | word fields
//   ---------+-----------+----------------------+------------------------------
//   req_     | in        | req_valid/req_stall  | func, value
//   rsp_     | out       | rsp_valid/rsp_stall  | status, entry_value, last_result
//
// Append, prepend and delete need no walk: every cell compares against the
// operand and shifts in parallel, so a new request word can be taken each
// cycle while the response register drains.
// A listing of n entries holds requests off after it is taken until its last
// entry has been issued: the cell row rotates once per word and cell 0 feeds
// the response.
// Reset (synchronous, active high) empties the list; cell contents are not
// cleared, only the fill count and the walk counter.
// req_stall rises whenever the response register is full and stalled, and
// for the whole of a listing walk.
//
module ordered_list_insert_delete_top #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEF   // 2 .. 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [olid_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [olid_pkg::DATA_W-1:0]   req_value,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [olid_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [olid_pkg::DATA_W-1:0]   rsp_entry_value,
   output logic                                 rsp_last_result
);
   import olid_pkg::*;

   cmd_type       cmd;        // one operation per cycle from controller, none while the output is stalled
   dp_status_type dp_status;  // empty / single entry / walk at tail

   // decode, listing walk, response valid
   olid_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // cell row, fill count and response word payload
   olid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_value       (req_value),
      .dp_status       (dp_status),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last_result (rsp_last_result)
   );

endmodule
